### rtl/connection_protocol_classifier_defines.svh
// Assertion macros for the connection protocol classifier.
`ifndef CONNECTION_PROTOCOL_CLASSIFIER_DEFINES_SVH
`define CONNECTION_PROTOCOL_CLASSIFIER_DEFINES_SVH
`ifndef SYNTHESIS
`define CPC_ASSERT_IMP(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
`define CPC_ASSERT_NXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`else
`define CPC_ASSERT_IMP(label, clk, rst_n, a, c)
`define CPC_ASSERT_NXT(label, clk, rst_n, a, c)
`endif
`endif

### rtl/cpc_pkg.sv
// Package: types and constants for the connection protocol classifier.
`timescale 1ns / 1ps
`default_nettype none
package cpc_pkg;
    localparam int NUM_PREFIX = 23;
    localparam int MAX_PLEN   = 10;
    localparam int NUM_HDR    = 4;

    typedef enum logic [1:0] {
        TAG_SCANNING = 2'd0,
        TAG_FOUND    = 2'd1,
        TAG_FAILED   = 2'd2
    } tag_state_t;

    typedef enum logic [3:0] {
        ENT_API = 4'd0, ENT_WS = 4'd1, ENT_TLS = 4'd2, ENT_SOCKS5 = 4'd3,
        ENT_SOCKS4 = 4'd4, ENT_FTP = 4'd5, ENT_HTTP = 4'd6, ENT_SMTP = 4'd7,
        ENT_IMAP = 4'd8
    } entry_t;

    // Lower-case ASCII A-Z only.
    function automatic logic [7:0] fold_case(input logic [7:0] c);
        fold_case = (c >= 8'h41 && c <= 8'h5a) ? (c + 8'd32) : c;
    endfunction

    function automatic logic is_alnum(input logic [7:0] c);
        is_alnum = (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5a) ||
                   (c >= 8'h61 && c <= 8'h7a);
    endfunction

    function automatic logic [3:0] prefix_len(input int i);
        logic [3:0] r;
        r = 4'd0;
        case (i)
            0: r = 4'd9;   1: r = 4'd4;   2: r = 4'd5;   3: r = 4'd5;
            4: r = 4'd4;   5: r = 4'd4;   6: r = 4'd5;   7: r = 4'd5;
            8: r = 4'd4;   9: r = 4'd4;   10: r = 4'd4;  11: r = 4'd5;
            12: r = 4'd4;  13: r = 4'd7;  14: r = 4'd5;  15: r = 4'd8;
            16: r = 4'd8;  17: r = 4'd6;  18: r = 4'd6;  19: r = 4'd5;
            20: r = 4'd5;  21: r = 4'd10; 22: r = 4'd8;
            default: r = 4'd0;
        endcase
        return r;
    endfunction

    function automatic logic prefix_fold(input int i);
        return (i >= 2 && i <= 7) || (i >= 19);
    endfunction

    function automatic logic [79:0] prefix_text(input int i);
        logic [79:0] r;
        r = '0;
        case (i)
            0: r = "GET /api/";   1: r = "GET ";      2: r = "USER ";
            3: r = "PASS ";       4: r = "LIST";      5: r = "PASV";
            6: r = "RETR ";       7: r = "STOR ";     8: r = "220 ";
            9: r = "331 ";        10: r = "GET ";     11: r = "POST ";
            12: r = "PUT ";       13: r = "DELETE ";  14: r = "HEAD ";
            15: r = "OPTIONS ";   16: r = "CONNECT "; 17: r = "PATCH ";
            18: r = "TRACE ";     19: r = "HELO ";    20: r = "EHLO ";
            21: r = "MAIL FROM:"; 22: r = "RCPT TO:";
            default: r = '0;
        endcase
        return r;
    endfunction

    // Character p of prefix i, case-folded where the prefix folds.
    function automatic logic [7:0] prefix_char(input int i, input int p);
        logic [79:0] t;
        logic [7:0]  c;
        int          l;
        t = prefix_text(i);
        l = int'(prefix_len(i));
        c = t[(l - 1 - p) * 8 +: 8];
        return prefix_fold(i) ? fold_case(c) : c;
    endfunction

    function automatic logic [175:0] header_text(input int h);
        logic [175:0] r;
        r = '0;
        case (h)
            0: r = "upgrade: websocket";
            1: r = "connection:";
            2: r = "sec-websocket-key:";
            3: r = "sec-websocket-version:";
            default: r = '0;
        endcase
        return r;
    endfunction

    function automatic int header_len(input int h);
        int r;
        r = 0;
        case (h)
            0: r = 18; 1: r = 11; 2: r = 18; 3: r = 22;
            default: r = 0;
        endcase
        return r;
    endfunction

    // Character k (0 = oldest) of header h.
    function automatic logic [7:0] header_char(input int h, input int k);
        logic [175:0] t;
        t = header_text(h);
        return t[(header_len(h) - 1 - k) * 8 +: 8];
    endfunction
endpackage
`default_nettype wire

### rtl/cpc_window_cell.sv
// One cell of the lower-cased byte window: holds a byte, shifts it onward.
`timescale 1ns / 1ps
`default_nettype none
module cpc_window_cell
    import cpc_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       shift_en,
    input  wire logic       clear,
    input  wire logic [7:0] byte_in,
    output logic      [7:0] byte_out
);
    logic [7:0] byte_reg;
    logic [7:0] byte_next;

    always_comb
    begin
        byte_next = byte_reg;
        if (clear)
        begin
            byte_next = 8'd0;
        end
        else if (shift_en)
        begin
            byte_next = byte_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_reg <= 8'd0;
        end
        else
        begin
            byte_reg <= byte_next;
        end
    end

    assign byte_out = byte_reg;
endmodule
`default_nettype wire

### rtl/connection_protocol_classifier.sv
// Top level: byte-serial protocol signature classifier.
`timescale 1ns / 1ps
`default_nettype none
`include "connection_protocol_classifier_defines.svh"
// Classifies the first payload of a connection. Each request carries one byte
// and a last-byte flag; one request is accepted per cycle unless stalled, and
// only the request with last_byte set produces a response (matched, protocol,
// entry), which is registered on acceptance. While a response waits and
// out_ready is low, the input stalls for every byte; with out_ready high the
// response drains and the next byte is taken in the same cycle. Per-payload
// state (prefix flags, position, first three bytes, tag scan, header hits)
// resets itself after the last byte. The header search runs on a row of
// WINDOW_BYTES byte cells that shift the lower-cased byte stream by one cell
// per accepted byte until a zero byte; the header compares read fixed taps of
// the row and the incoming byte, so one byte a cycle is kept unless stalled.
module connection_protocol_classifier
    import cpc_pkg::*;
#(
    parameter int WINDOW_BYTES   = 22,
    parameter int TAG_SCAN_LIMIT = 20
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic [7:0] data_byte,
    input  wire logic       last_byte,
    input  wire logic       in_valid,
    output logic            in_ready,
    output logic            matched,
    output logic      [2:0] protocol,
    output logic      [3:0] entry,
    output logic            out_valid,
    input  wire logic       out_ready
);
    logic                  accept;
    logic [4:0]            pos_reg, pos_next;
    logic [NUM_PREFIX-1:0] alive_reg, alive_next;
    logic [7:0]            head_reg [3];
    tag_state_t            tag_reg, tag_next;
    logic [NUM_HDR-1:0]    hdr_reg, hdr_next;
    logic                  zero_reg, zero_next;
    logic                  res_v_reg;
    logic                  res_m_reg;
    logic [3:0]            res_e_reg;
    logic [7:0]            fb;
    logic                  shift_en;
    logic                  zero_now;
    logic [7:0]            win [WINDOW_BYTES];
    logic [NUM_HDR-1:0]    hdr_hit;
    logic [7:0]            h0, h1, h2;
    logic [4:0]            len;
    logic                  e_ok;
    logic [3:0]            e_val;

    assign in_ready = !res_v_reg || out_ready;
    assign accept   = in_valid && in_ready;
    assign fb       = fold_case(data_byte);
    assign zero_now = zero_reg || (data_byte == 8'd0);
    assign shift_en = accept && !zero_now;

    // Row of window cells; cell WINDOW_BYTES-1 holds the newest byte.
    for (genvar g = 0; g < WINDOW_BYTES; g++)
    begin : g_win
        cpc_window_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .shift_en (shift_en),
            .clear    (accept && last_byte),
            .byte_in  ((g == WINDOW_BYTES - 1) ? fb : win[(g + 1) % WINDOW_BYTES]),
            .byte_out (win[g])
        );
    end

    // Header compares on the window as it will be after this byte.
    always_comb
    begin
        int n;
        hdr_hit = '0;
        for (int h = 0; h < NUM_HDR; h++)
        begin
            n = header_len(h);
            hdr_hit[h] = (fb == header_char(h, n - 1));
            for (int k = 0; k < n - 1; k++)
            begin
                if (win[WINDOW_BYTES - n + 1 + k] != header_char(h, k))
                begin
                    hdr_hit[h] = 1'b0;
                end
            end
        end
    end

    always_comb
    begin
        alive_next = alive_reg;
        for (int i = 0; i < NUM_PREFIX; i++)
        begin
            for (int p = 0; p < MAX_PLEN; p++)
            begin
                if (pos_reg == 5'(p) && p < int'(prefix_len(i)))
                begin
                    if ((prefix_fold(i) ? fb : data_byte) != prefix_char(i, p))
                    begin
                        alive_next[i] = 1'b0;
                    end
                end
            end
        end
    end

    always_comb
    begin
        tag_next = tag_reg;
        if (tag_reg == TAG_SCANNING)
        begin
            if (pos_reg == 5'd0)
            begin
                if (!is_alnum(data_byte))
                begin
                    tag_next = TAG_FAILED;
                end
            end
            else if (pos_reg < 5'(TAG_SCAN_LIMIT))
            begin
                if (data_byte == 8'h20)
                begin
                    tag_next = TAG_FOUND;
                end
                else if (!is_alnum(data_byte))
                begin
                    tag_next = TAG_FAILED;
                end
            end
            else
            begin
                tag_next = TAG_FAILED;
            end
        end
    end

    assign zero_next = zero_now;
    assign hdr_next  = zero_now ? hdr_reg : (hdr_reg | hdr_hit);
    assign pos_next  = (pos_reg == 5'd31) ? pos_reg : pos_reg + 5'd1;

    // Final decision on the state after this byte.
    assign h0  = (pos_reg == 5'd0) ? data_byte : head_reg[0];
    assign h1  = (pos_reg == 5'd1) ? data_byte : head_reg[1];
    assign h2  = (pos_reg == 5'd2) ? data_byte : head_reg[2];
    assign len = pos_next;

    always_comb
    begin
        logic ftp_h, http_h, smtp_h;
        ftp_h  = 1'b0;
        http_h = 1'b0;
        smtp_h = 1'b0;
        for (int i = 2; i < NUM_PREFIX; i++)
        begin
            if (alive_next[i] && len >= 5'(prefix_len(i)))
            begin
                if (i <= 9) ftp_h = 1'b1;
                else if (i <= 18) http_h = 1'b1;
                else smtp_h = 1'b1;
            end
        end
        e_ok  = 1'b1;
        e_val = ENT_API;
        if (alive_next[0] && len >= 5'd9)
            e_val = ENT_API;
        else if (alive_next[1] && len >= 5'd4 && hdr_next == 4'hf)
            e_val = ENT_WS;
        else if (len >= 5'd5 && h0 == 8'h16 && h1 == 8'h03 && h2 <= 8'h04)
            e_val = ENT_TLS;
        else if (len >= 5'd2 && h0 == 8'h05 && h1 >= 8'd1 && h1 <= 8'd16)
            e_val = ENT_SOCKS5;
        else if (h0 == 8'h04)
            e_val = ENT_SOCKS4;
        else if (ftp_h)
            e_val = ENT_FTP;
        else if (http_h)
            e_val = ENT_HTTP;
        else if (smtp_h)
            e_val = ENT_SMTP;
        else if (tag_next == TAG_FOUND)
            e_val = ENT_IMAP;
        else
        begin
            e_ok  = 1'b0;
            e_val = ENT_API;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg     <= 5'd0;
            alive_reg   <= '1;
            head_reg[0] <= 8'd0;
            head_reg[1] <= 8'd0;
            head_reg[2] <= 8'd0;
            tag_reg     <= TAG_SCANNING;
            hdr_reg     <= '0;
            zero_reg    <= 1'b0;
        end
        else if (accept)
        begin
            if (last_byte)
            begin
                pos_reg     <= 5'd0;
                alive_reg   <= '1;
                head_reg[0] <= 8'd0;
                head_reg[1] <= 8'd0;
                head_reg[2] <= 8'd0;
                tag_reg     <= TAG_SCANNING;
                hdr_reg     <= '0;
                zero_reg    <= 1'b0;
            end
            else
            begin
                pos_reg     <= pos_next;
                alive_reg   <= alive_next;
                head_reg[0] <= h0;
                head_reg[1] <= h1;
                head_reg[2] <= h2;
                tag_reg     <= tag_next;
                hdr_reg     <= hdr_next;
                zero_reg    <= zero_next;
            end
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_v_reg <= 1'b0;
        end
        else if (accept && last_byte)
        begin
            res_v_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            res_v_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && last_byte)
        begin
            res_m_reg <= e_ok;
            res_e_reg <= e_val;
        end
    end

    assign out_valid = res_v_reg;
    assign matched   = res_m_reg;
    assign entry     = res_e_reg;
    // Entries 3 and 4 share protocol socks.
    assign protocol  = (res_e_reg >= 4'd4) ? 3'(res_e_reg - 4'd1) : res_e_reg[2:0];

    `CPC_ASSERT_IMP(a_no_accept_when_full, clk, rst_n, res_v_reg && !out_ready, !in_ready)
    `CPC_ASSERT_NXT(a_last_gives_result, clk, rst_n, accept && last_byte, out_valid)
    `CPC_ASSERT_NXT(a_state_cleared, clk, rst_n, accept && last_byte, pos_reg == 5'd0)
    `CPC_ASSERT_IMP(a_nomatch_zero, clk, rst_n, out_valid && !matched, entry == 4'd0)
endmodule
`default_nettype wire

### sim/tb.sv
// Self-checking testbench for connection_protocol_classifier.
`timescale 1ns / 1ps
`default_nettype none
module tb;
    import cpc_pkg::*;

    // Protocol codes on the response.
    localparam logic [2:0] PROTO_API = 3'd0;
    localparam logic [2:0] PROTO_WS  = 3'd1;
    localparam logic [2:0] PROTO_TLS = 3'd2;
    localparam logic [2:0] PROTO_SOCKS = 3'd3;
    localparam logic [2:0] PROTO_FTP = 3'd4;
    localparam logic [2:0] PROTO_HTTP = 3'd5;
    localparam logic [2:0] PROTO_SMTP = 3'd6;
    localparam logic [2:0] PROTO_IMAP = 3'd7;
    localparam int TAG_LIMIT = 20;
    localparam int WIN = 22;
    localparam int N_BYTES = 330;
    localparam int HOLD_CYCLES = 40;

    typedef struct packed {
        logic       hit;
        logic [2:0] proto;
        logic [3:0] ent;
    } verdict_t;

    typedef struct {
        logic [7:0] b;
        bit         last;
        bit         drain;
    } byte_req_t;

    typedef struct {
        string    txt;
        int       zero_at;
        bit       typed;
        verdict_t want;
    } row_t;

    logic       clk;
    logic       rst_n;
    logic [7:0] data_byte;
    logic       last_byte;
    logic       in_valid;
    logic       in_ready;
    logic       matched;
    logic [2:0] protocol;
    logic [3:0] entry;
    logic       out_valid;
    logic       out_ready;

    connection_protocol_classifier u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .data_byte (data_byte),
        .last_byte (last_byte),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .matched   (matched),
        .protocol  (protocol),
        .entry     (entry),
        .out_valid (out_valid),
        .out_ready (out_ready)
    );

    // Signature prefixes in priority order; bit set in sig_fold = case-blind.
    string sig_text [23] = '{"GET /api/", "GET ", "USER ", "PASS ", "LIST", "PASV",
        "RETR ", "STOR ", "220 ", "331 ", "GET ", "POST ", "PUT ", "DELETE ",
        "HEAD ", "OPTIONS ", "CONNECT ", "PATCH ", "TRACE ", "HELO ", "EHLO ",
        "MAIL FROM:", "RCPT TO:"};
    localparam logic [22:0] SIG_FOLD = 23'h7800FC;
    string ws_hdr [4] = '{"upgrade: websocket", "connection:", "sec-websocket-key:",
        "sec-websocket-version:"};
    localparam string WS_REQ = {"GET /chat HTTP/1.1\015\nUpgrade: WebSocket\015\n",
        "Connection: Upgrade\015\nSec-WebSocket-Key: k\015\nSec-WebSocket-Version: 13\015\n"};

    // Predictor state: one payload in flight on the input side.
    int          pos;
    logic [22:0] alive;
    logic [7:0]  head [3];
    tag_state_t  tag;
    logic [7:0]  win [WIN];
    logic [3:0]  hdr_hit;
    bit          zseen;

    verdict_t    pending_verdicts [$];
    byte_req_t   stim_q [$];
    int          n_fail;
    int          n_results;
    int          n_sent;
    int          n_total;
    int          n_matched;
    bit          calm;

    function automatic logic [7:0] lower(input logic [7:0] c);
        return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
    endfunction

    function automatic bit alnum(input logic [7:0] c);
        return (c >= "0" && c <= "9") || (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
    endfunction

    function automatic void clear_payload_state();
        pos = 0;
        alive = '1;
        tag = TAG_SCANNING;
        hdr_hit = '0;
        zseen = 0;
        for (int i = 0; i < 3; i++) head[i] = '0;
        for (int i = 0; i < WIN; i++) win[i] = '0;
    endfunction

    function automatic bit sig_alive(input int i, input int len);
        return alive[i] && len >= sig_text[i].len();
    endfunction

    function automatic bit group_alive(input int lo, input int hi, input int len);
        for (int i = lo; i <= hi; i++)
            if (sig_alive(i, len)) return 1;
        return 0;
    endfunction

    // Advance the payload state by one byte; on the last byte give the verdict.
    function automatic void classify_byte(input logic [7:0] b, input bit last,
                                          output bit fire, output verdict_t v);
        logic [7:0] pc;
        logic [7:0] dc;
        int         n;
        bit         ok;
        bit         any;
        entry_t     e;
        fire = 0;
        v = '0;
        for (int i = 0; i < 23; i++) begin
            if (pos < sig_text[i].len()) begin
                pc = sig_text[i][pos];
                dc = b;
                if (SIG_FOLD[i]) begin
                    pc = lower(pc);
                    dc = lower(dc);
                end
                if (pc != dc) alive[i] = 1'b0;
            end
        end
        if (pos < 3) head[pos] = b;
        if (tag == TAG_SCANNING) begin
            if (pos == 0) begin
                if (!alnum(b)) tag = TAG_FAILED;
            end else if (pos < TAG_LIMIT) begin
                if (b == " ") tag = TAG_FOUND;
                else if (!alnum(b)) tag = TAG_FAILED;
            end else begin
                tag = TAG_FAILED;
            end
        end
        if (b == 8'h00) zseen = 1;
        if (!zseen) begin
            for (int k = 0; k < WIN - 1; k++) win[k] = win[k + 1];
            win[WIN - 1] = lower(b);
            for (int h = 0; h < 4; h++) begin
                n = ws_hdr[h].len();
                ok = 1;
                for (int k = 0; k < n; k++)
                    if (win[WIN - n + k] != ws_hdr[h][k]) ok = 0;
                if (ok) hdr_hit[h] = 1'b1;
            end
        end
        if (pos < 31) pos++;
        if (!last) return;
        fire = 1;
        any = 1;
        e = ENT_API;
        if (sig_alive(0, pos)) e = ENT_API;
        else if (sig_alive(1, pos) && hdr_hit == 4'hF) e = ENT_WS;
        else if (pos >= 5 && head[0] == 8'h16 && head[1] == 8'h03 && head[2] <= 8'h04)
            e = ENT_TLS;
        else if (pos >= 2 && head[0] == 8'h05 && head[1] >= 8'd1 && head[1] <= 8'd16)
            e = ENT_SOCKS5;
        else if (head[0] == 8'h04) e = ENT_SOCKS4;
        else if (group_alive(2, 9, pos)) e = ENT_FTP;
        else if (group_alive(10, 18, pos)) e = ENT_HTTP;
        else if (group_alive(19, 22, pos)) e = ENT_SMTP;
        else if (tag == TAG_FOUND) e = ENT_IMAP;
        else any = 0;
        if (any) begin
            v.hit = 1'b1;
            v.ent = e;
            v.proto = (e <= ENT_SOCKS5) ? 3'(e) : 3'(e - 1);
        end
        clear_payload_state();
    endfunction

    function automatic void push_byte(input logic [7:0] b, input bit last);
        byte_req_t r;
        r.b = b;
        r.last = last;
        r.drain = 0;
        stim_q.push_back(r);
    endfunction

    function automatic void push_drain();
        byte_req_t r;
        r.b = '0;
        r.last = 0;
        r.drain = 1;
        stim_q.push_back(r);
    endfunction

    // Text with optional random case flips, a stray zero and a random tail.
    function automatic void push_text(input string s, input bit mix_case, input int zero_at,
                                      input int tail);
        logic [7:0] c;
        for (int i = 0; i < s.len(); i++) begin
            if (i == zero_at) push_byte(8'h00, 0);
            c = s[i];
            if (mix_case && alnum(c) && c >= "A" && $urandom_range(0, 1))
                c = c ^ 8'h20;
            push_byte(c, tail == 0 && i == s.len() - 1);
        end
        for (int i = 0; i < tail; i++)
            push_byte($urandom_range(0, 3) == 0 ? 8'($urandom) : 8'($urandom_range(32, 126)),
                      i == tail - 1);
    endfunction

    function automatic void push_random_payload();
        int    n;
        int    kind;
        string tagstr;
        kind = $urandom_range(0, 29);
        if (kind < 17) begin
            n = $urandom_range(0, 22);
            push_text(sig_text[n], SIG_FOLD[n] || $urandom_range(0, 7) == 0,
                      $urandom_range(0, 7) == 0 ? $urandom_range(0, 9) : -1,
                      $urandom_range(0, 6));
        end else if (kind < 21) begin
            // binary heads around the TLS and SOCKS boundaries
            n = $urandom_range(1, 7);
            case ($urandom_range(0, 2))
                0: push_byte(8'h16, n == 1);
                1: push_byte(8'h05, n == 1);
                default: push_byte(8'h04, n == 1);
            endcase
            for (int i = 1; i < n; i++) begin
                if (i == 1 && $urandom_range(0, 1)) push_byte(8'h03, i == n - 1);
                else push_byte(8'($urandom_range(0, 20)), i == n - 1);
            end
        end else if (kind < 26) begin
            tagstr = "";
            n = $urandom_range(1, 22);
            for (int i = 0; i < n; i++)
                tagstr = {tagstr, string'(8'($urandom_range(0, 2) == 0 ?
                    $urandom_range(48, 57) : $urandom_range(97, 122)))};
            push_text({tagstr, " "}, 1, -1, $urandom_range(0, 4));
        end else if (kind == 26) begin
            push_text(WS_REQ, 1, $urandom_range(0, 2) == 0 ? $urandom_range(4, 90) : -1, 0);
        end else begin
            n = $urandom_range(1, 40);
            for (int i = 0; i < n; i++) push_byte(8'($urandom), i == n - 1);
        end
    endfunction

    function automatic verdict_t mk(input logic h, input logic [2:0] p, input entry_t e);
        verdict_t v;
        v.hit = h;
        v.proto = p;
        v.ent = e;
        return v;
    endfunction

    // Directed table; rows with typed = 0 rely on the predictor.
    row_t rows [$];
    byte_req_t row_bytes [$];
    verdict_t  typed_q [$];

    function automatic void build_stimulus();
        int base;
        rows = '{
            '{"GET /api/v1", -1, 1, mk(1, PROTO_API, ENT_API)},
            '{WS_REQ, -1, 1, mk(1, PROTO_WS, ENT_WS)},
            '{WS_REQ, 40, 0, '0},
            '{"\026\003\004ab", -1, 1, mk(1, PROTO_TLS, ENT_TLS)},
            '{"\026\003\005ab", -1, 0, '0},
            '{"\026\003\001a", -1, 1, mk(0, PROTO_API, ENT_API)},
            '{"\005\001", -1, 1, mk(1, PROTO_SOCKS, ENT_SOCKS5)},
            '{"\005\020", -1, 1, mk(1, PROTO_SOCKS, ENT_SOCKS5)},
            '{"\005\021", -1, 1, mk(0, PROTO_API, ENT_API)},
            '{"\004", -1, 1, mk(1, PROTO_SOCKS, ENT_SOCKS4)},
            '{"uSeR bob", -1, 1, mk(1, PROTO_FTP, ENT_FTP)},
            '{"220 ready", -1, 1, mk(1, PROTO_FTP, ENT_FTP)},
            '{"pasv", -1, 1, mk(1, PROTO_FTP, ENT_FTP)},
            '{"OPTIONS *", -1, 1, mk(1, PROTO_HTTP, ENT_HTTP)},
            '{"DELETE /x", -1, 1, mk(1, PROTO_HTTP, ENT_HTTP)},
            '{"TRACE /", -1, 0, '0},
            '{"Mail From:<a>", -1, 1, mk(1, PROTO_SMTP, ENT_SMTP)},
            '{"rcpt to:", -1, 0, '0},
            '{"a1 LOGIN", -1, 1, mk(1, PROTO_IMAP, ENT_IMAP)},
            '{"abcdefghijklmnopqrs x", -1, 1, mk(1, PROTO_IMAP, ENT_IMAP)},
            '{"abcdefghijklmnopqrst x", -1, 1, mk(0, PROTO_API, ENT_API)},
            '{"a", -1, 1, mk(0, PROTO_API, ENT_API)},
            '{"\377", -1, 1, mk(0, PROTO_API, ENT_API)},
            '{"GET /api", 3, 0, '0},
            '{"0123456789012345678901234567890123456789", -1, 0, '0}
        };
        foreach (rows[r]) begin
            push_text(rows[r].txt, 0, rows[r].zero_at, 0);
            typed_q.push_back(rows[r].typed ? rows[r].want : '1);
        end
        push_drain();
        base = stim_q.size();
        while (stim_q.size() - base < N_BYTES) begin
            push_random_payload();
            if (stim_q.size() - base >= N_BYTES / 2 && stim_q.size() - base < N_BYTES / 2 + 40)
                push_drain();
        end
    endfunction

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Request side: one byte per handshake, random bursts of gaps.
    initial begin
        bit       fire;
        verdict_t v;
        byte_req_t r;
        rst_n = 1'b0;
        in_valid = 1'b0;
        data_byte = '0;
        last_byte = 1'b0;
        n_fail = 0;
        n_sent = 0;
        calm = 0;
        clear_payload_state();
        build_stimulus();
        foreach (stim_q[i]) if (!stim_q[i].drain) n_total++;
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        while (stim_q.size() > 0) begin
            r = stim_q.pop_front();
            @(negedge clk);
            if (r.drain) begin
                // sender pause: let every pending response come out
                in_valid <= 1'b0;
                while (pending_verdicts.size() > 0) @(negedge clk);
                continue;
            end
            if (!calm && $urandom_range(0, 5) == 0) begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 3)) @(negedge clk);
            end
            in_valid <= 1'b1;
            data_byte <= r.b;
            last_byte <= r.last;
            do @(posedge clk); while (!in_ready);
            classify_byte(r.b, r.last, fire, v);
            if (fire) begin
                // typed directed rows override the predictor's verdict
                if (typed_q.size() > 0) begin
                    if (typed_q[0] !== '1) v = typed_q[0];
                    void'(typed_q.pop_front());
                end
                pending_verdicts.push_back(v);
            end
            n_sent++;
            if (n_sent * 10 > n_total * 8) calm = 1;
        end
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_verdicts.size() > 0) @(posedge clk);
        repeat (10) @(posedge clk);
        $display("Sent %0d bytes, checked %0d verdicts (%0d matched a signature).",
                 n_sent, n_results, n_matched);
        $display("Covered every signature, zero-cut headers, tag limits and back-pressure.");
        if (n_fail == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // Response side: short random stalls plus one long hold to back up the input.
    initial begin
        bit held;
        held = 0;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever begin
            @(negedge clk);
            if (!held && n_results >= 15) begin
                held = 1;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                out_ready <= 1'b1;
            end else if (!calm && $urandom_range(0, 4) == 0) begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 3)) @(negedge clk);
                out_ready <= 1'b1;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    // Compare each accepted response with the oldest pending verdict.
    always @(posedge clk) begin
        verdict_t w;
        if (rst_n && out_valid && out_ready) begin
            if (pending_verdicts.size() == 0) begin
                $error("response with no pending verdict");
                n_fail++;
            end else begin
                w = pending_verdicts.pop_front();
                n_results++;
                if (w.hit) n_matched++;
                if (matched !== w.hit) begin
                    $error("matched: expected %0d, got %0d", w.hit, matched);
                    n_fail++;
                end
                if (protocol !== w.proto) begin
                    $error("protocol: expected %0d, got %0d", w.proto, protocol);
                    n_fail++;
                end
                if (entry !== w.ent) begin
                    $error("entry: expected %0d, got %0d", w.ent, entry);
                    n_fail++;
                end
            end
        end
    end

    initial begin
        #200000;
        $display("== FAIL ==");
        $finish;
    end
endmodule
`default_nettype wire
